FILE: design/cbu_pkg.sv
`default_nettype none

package cbu_pkg;

   // opcodes of the handled control-flow instructions
   localparam logic [7:0] OP_JR      = 8'h18;
   localparam logic [7:0] OP_JR_NZ   = 8'h20;
   localparam logic [7:0] OP_JR_Z    = 8'h28;
   localparam logic [7:0] OP_JR_NC   = 8'h30;
   localparam logic [7:0] OP_JR_C    = 8'h38;
   localparam logic [7:0] OP_JP      = 8'hC3;
   localparam logic [7:0] OP_JP_NZ   = 8'hC2;
   localparam logic [7:0] OP_JP_Z    = 8'hCA;
   localparam logic [7:0] OP_JP_NC   = 8'hD2;
   localparam logic [7:0] OP_JP_C    = 8'hDA;
   localparam logic [7:0] OP_CALL    = 8'hCD;
   localparam logic [7:0] OP_CALL_NZ = 8'hC4;
   localparam logic [7:0] OP_CALL_Z  = 8'hCC;
   localparam logic [7:0] OP_CALL_NC = 8'hD4;
   localparam logic [7:0] OP_CALL_C  = 8'hDC;
   localparam logic [7:0] OP_RET     = 8'hC9;
   localparam logic [7:0] OP_RETI    = 8'hD9;
   localparam logic [7:0] OP_RET_NZ  = 8'hC0;
   localparam logic [7:0] OP_RET_Z   = 8'hC8;
   localparam logic [7:0] OP_RET_NC  = 8'hD0;
   localparam logic [7:0] OP_RET_C   = 8'hD8;
   localparam logic [7:0] OP_JP_HL   = 8'hE9;
   localparam logic [7:0] OP_HALT    = 8'h76;
   localparam logic [7:0] RST_MASK   = 8'hC7;
   localparam logic [7:0] RST_TARGET = 8'h38;

   // condition field, opcode bits 4..3
   localparam logic [1:0] COND_NZ = 2'd0;
   localparam logic [1:0] COND_Z  = 2'd1;
   localparam logic [1:0] COND_NC = 2'd2;
   localparam logic [1:0] COND_C  = 2'd3;

   // cycle counts
   localparam logic [4:0] CYC_4  = 5'd4;
   localparam logic [4:0] CYC_8  = 5'd8;
   localparam logic [4:0] CYC_12 = 5'd12;
   localparam logic [4:0] CYC_16 = 5'd16;
   localparam logic [4:0] CYC_20 = 5'd20;
   localparam logic [4:0] CYC_24 = 5'd24;

   // interrupt-enable delay codes
   localparam logic [1:0] IE_NONE  = 2'd0;
   localparam logic [1:0] IE_SHORT = 2'd1;
   localparam logic [1:0] IE_LONG  = 2'd2;

   typedef struct packed {
      logic [7:0]  mode;
      logic [7:0]  imm_low;
      logic [7:0]  imm_high;
      logic        zero_flag;
      logic        carry_flag;
      logic [15:0] pc_now;
      logic [15:0] sp_now;
      logic [15:0] hl_value;
      logic [15:0] stack_word;
      logic [7:0]  next_byte;
   } cbu_req_type;

   typedef struct packed {
      logic [15:0] pc_next;
      logic [15:0] sp_next;
      logic        push_valid;
      logic [15:0] push_address;
      logic [15:0] push_word;
      logic [4:0]  cycles;
      logic [1:0]  ie_countdown;
      logic        taken;
      logic        illegal;
   } cbu_rsp_type;

endpackage

`default_nettype wire

FILE: design/cpu_branch_unit_top.sv
// cpu_branch_unit_top: executes one control-flow instruction (JR, JP, CALL,
// RET, RETI, RST, JP HL) of an 8-bit handheld CPU per transfer.
// Input channel req_*: opcode, immediates, flags, pc, sp, hl, stack word and
// the byte at pc. Result channel rsp_*: next pc and sp, optional return
// address push, cycle count, RETI interrupt-enable delay, taken and illegal.
// Both channels use valid/ready; a transfer happens when both are high.
// Path: a transferred request is held in the input register, decoded
// combinationally, and its result held in the result register that drives
// rsp_*. Throughput: one instruction per clock while the receiver takes
// results, set by the single decode stage between the two registers.
// When the receiver stalls, the result register holds and the input
// register still takes one more request; req_ready drops only when both
// are full. Reset (synchronous, active high) empties both stages; there
// is no other state.
`default_nettype none

module cpu_branch_unit_top
   import cbu_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [7:0]  req_mode,
   input  wire  [7:0]  req_imm_low,
   input  wire  [7:0]  req_imm_high,
   input  wire         req_zero_flag,
   input  wire         req_carry_flag,
   input  wire  [15:0] req_pc_now,
   input  wire  [15:0] req_sp_now,
   input  wire  [15:0] req_hl_value,
   input  wire  [15:0] req_stack_word,
   input  wire  [7:0]  req_next_byte,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [15:0] rsp_pc_next,
   output logic [15:0] rsp_sp_next,
   output logic        rsp_push_valid,
   output logic [15:0] rsp_push_address,
   output logic [15:0] rsp_push_word,
   output logic [4:0]  rsp_cycles,
   output logic [1:0]  rsp_ie_countdown,
   output logic        rsp_taken,
   output logic        rsp_illegal
);

   cbu_req_type req_ff;
   cbu_req_type req_in;
   logic        req_valid_ff;
   cbu_rsp_type rsp_ff;
   cbu_rsp_type rsp_in;
   logic        rsp_valid_ff;
   logic        out_advance;
   logic        in_advance;

   // stage handshakes
   assign out_advance = !rsp_valid_ff || rsp_ready;
   assign in_advance  = !req_valid_ff || out_advance;
   assign req_ready   = in_advance;

   assign req_in = '{
      mode:       req_mode,
      imm_low:    req_imm_low,
      imm_high:   req_imm_high,
      zero_flag:  req_zero_flag,
      carry_flag: req_carry_flag,
      pc_now:     req_pc_now,
      sp_now:     req_sp_now,
      hl_value:   req_hl_value,
      stack_word: req_stack_word,
      next_byte:  req_next_byte
   };

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (in_advance) begin
         req_valid_ff <= req_valid;
      end
      if (in_advance && req_valid) begin
         req_ff <= req_in;
      end
   end

   cbu_decode u_decode (
      .req (req_ff),
      .rsp (rsp_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_advance) begin
         rsp_valid_ff <= req_valid_ff;
      end
      if (out_advance && req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pc_next      = rsp_ff.pc_next;
   assign rsp_sp_next      = rsp_ff.sp_next;
   assign rsp_push_valid   = rsp_ff.push_valid;
   assign rsp_push_address = rsp_ff.push_address;
   assign rsp_push_word    = rsp_ff.push_word;
   assign rsp_cycles       = rsp_ff.cycles;
   assign rsp_ie_countdown = rsp_ff.ie_countdown;
   assign rsp_taken        = rsp_ff.taken;
   assign rsp_illegal      = rsp_ff.illegal;

endmodule

`default_nettype wire

FILE: design/cbu_decode.sv
`default_nettype none

module cbu_decode
   import cbu_pkg::*;
(
   input  wire cbu_req_type req,
   output cbu_rsp_type      rsp
);

   logic        cond_ok;
   logic [15:0] offset;
   logic [15:0] imm16;
   logic [15:0] sp_pop;
   logic [15:0] sp_push;
   logic        is_jr;
   logic        is_jp;
   logic        is_call;
   logic        is_ret;
   logic        is_ret_cc;

   // condition from opcode bits 4..3
   always_comb begin
      unique case (req.mode[4:3])
         COND_NZ: cond_ok = !req.zero_flag;
         COND_Z:  cond_ok = req.zero_flag;
         COND_NC: cond_ok = !req.carry_flag;
         COND_C:  cond_ok = req.carry_flag;
         default: cond_ok = 1'b0;
      endcase
   end

   assign offset  = {{8{req.imm_low[7]}}, req.imm_low};
   assign imm16   = {req.imm_high, req.imm_low};
   assign sp_pop  = req.sp_now + 16'd2;
   assign sp_push = req.sp_now - 16'd2;

   // instruction class decode
   assign is_jr = (req.mode == OP_JR) || (req.mode == OP_JR_NZ) || (req.mode == OP_JR_Z)
                  || (req.mode == OP_JR_NC) || (req.mode == OP_JR_C);
   assign is_jp = (req.mode == OP_JP) || (req.mode == OP_JP_NZ) || (req.mode == OP_JP_Z)
                  || (req.mode == OP_JP_NC) || (req.mode == OP_JP_C);
   assign is_call = (req.mode == OP_CALL) || (req.mode == OP_CALL_NZ)
                    || (req.mode == OP_CALL_Z) || (req.mode == OP_CALL_NC)
                    || (req.mode == OP_CALL_C);
   assign is_ret = (req.mode == OP_RET) || (req.mode == OP_RETI);
   assign is_ret_cc = (req.mode == OP_RET_NZ) || (req.mode == OP_RET_Z)
                      || (req.mode == OP_RET_NC) || (req.mode == OP_RET_C);

   // next pc, sp, push, cycle count, RETI ie delay, taken and illegal
   always_comb begin
      rsp              = '0;
      rsp.pc_next      = req.pc_now;
      rsp.sp_next      = req.sp_now;
      priority if (is_jr) begin
         rsp.taken   = (req.mode == OP_JR) || cond_ok;
         rsp.cycles  = rsp.taken ? CYC_12 : CYC_8;
         if (rsp.taken) begin
            rsp.pc_next = req.pc_now + offset;
         end
      end else if (is_jp) begin
         rsp.taken   = (req.mode == OP_JP) || cond_ok;
         rsp.cycles  = rsp.taken ? CYC_16 : CYC_12;
         if (rsp.taken) begin
            rsp.pc_next = imm16;
         end
      end else if (is_call) begin
         rsp.taken   = (req.mode == OP_CALL) || cond_ok;
         rsp.cycles  = rsp.taken ? CYC_24 : CYC_12;
         if (rsp.taken) begin
            rsp.pc_next      = imm16;
            rsp.sp_next      = sp_push;
            rsp.push_valid   = 1'b1;
            rsp.push_address = sp_push;
            rsp.push_word    = req.pc_now;
         end
      end else if (is_ret) begin
         rsp.taken   = 1'b1;
         rsp.cycles  = CYC_16;
         rsp.pc_next = req.stack_word;
         rsp.sp_next = sp_pop;
         if (req.mode == OP_RETI) begin
            rsp.ie_countdown = (req.next_byte == OP_HALT) ? IE_SHORT : IE_LONG;
         end
      end else if (is_ret_cc) begin
         rsp.taken   = cond_ok;
         rsp.cycles  = cond_ok ? CYC_20 : CYC_8;
         if (cond_ok) begin
            rsp.pc_next = req.stack_word;
            rsp.sp_next = sp_pop;
         end
      end else if ((req.mode & RST_MASK) == RST_MASK) begin
         rsp.taken        = 1'b1;
         rsp.cycles       = CYC_16;
         rsp.pc_next      = {8'd0, req.mode & RST_TARGET};
         rsp.sp_next      = sp_push;
         rsp.push_valid   = 1'b1;
         rsp.push_address = sp_push;
         rsp.push_word    = req.pc_now;
      end else if (req.mode == OP_JP_HL) begin
         rsp.taken   = 1'b1;
         rsp.cycles  = CYC_4;
         rsp.pc_next = req.hl_value;
      end else begin
         rsp.illegal = 1'b1;
      end
   end

endmodule

`default_nettype wire
